### rtl/core/assert_macros.svh
// Assertion helpers for the core RTL; rsp_emit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RSP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RSP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/rsp_pkg.sv
package rsp_pkg;

  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int EDGE_BITS  = COORD_BITS + 1;
  localparam int NUM_SLOTS  = 4;

  typedef enum logic [2:0] {
    KIND_LEFT   = 3'd0,
    KIND_RIGHT  = 3'd1,
    KIND_TOP    = 3'd2,
    KIND_BOTTOM = 3'd3,
    KIND_WHOLE  = 3'd4,
    KIND_NONE   = 3'd5
  } kind_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] subject_left;
    logic signed [COORD_BITS-1:0] subject_top;
    logic        [SIZE_BITS-1:0]  subject_wide;
    logic        [SIZE_BITS-1:0]  subject_tall;
    logic signed [COORD_BITS-1:0] cutter_left;
    logic signed [COORD_BITS-1:0] cutter_top;
    logic        [SIZE_BITS-1:0]  cutter_wide;
    logic        [SIZE_BITS-1:0]  cutter_tall;
  } item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] piece_left;
    logic signed [COORD_BITS-1:0] piece_top;
    logic        [SIZE_BITS-1:0]  piece_wide;
    logic        [SIZE_BITS-1:0]  piece_tall;
    kind_t                        piece_kind;
    logic                         last_piece;
  } result_t;

  // Set of candidate pieces for one item; slot order is emission order.
  typedef struct packed {
    result_t [NUM_SLOTS-1:0] slot;
    logic    [NUM_SLOTS-1:0] mask;
  } piece_set_t;

endpackage

### rtl/core/rsp_cut.sv
module rsp_cut
  import rsp_pkg::*;
(
  input  item_t      item,
  output piece_set_t pieces
);

  logic signed [EDGE_BITS-1:0] sl, st, sw, sh, cl, ct, cw, ch;
  logic signed [EDGE_BITS-1:0] sr, sb, cr, cb, xl, xr;
  logic                        overlap, covered;
  logic                        has_left, has_right, has_top, has_bottom;

  always_comb begin
    sl = $signed({item.subject_left[COORD_BITS-1], item.subject_left});
    st = $signed({item.subject_top[COORD_BITS-1], item.subject_top});
    sw = $signed({2'b00, item.subject_wide});
    sh = $signed({2'b00, item.subject_tall});
    cl = $signed({item.cutter_left[COORD_BITS-1], item.cutter_left});
    ct = $signed({item.cutter_top[COORD_BITS-1], item.cutter_top});
    cw = $signed({2'b00, item.cutter_wide});
    ch = $signed({2'b00, item.cutter_tall});
    sr = sl + sw;
    sb = st + sh;
    cr = cl + cw;
    cb = ct + ch;
    xl = (cl > sl) ? cl : sl;
    xr = (cr < sr) ? cr : sr;

    overlap    = (sl < cr) && (sr > cl) && (st < cb) && (sb > ct);
    covered    = (cl <= sl) && (cr >= sr) && (ct <= st) && (cb >= sb);
    has_left   = cl > sl;
    has_right  = cr < sr;
    has_top    = ct > st;
    has_bottom = cb < sb;
  end

  always_comb begin
    pieces = '0;
    if (!overlap) begin
      pieces.slot[0].piece_left = item.subject_left;
      pieces.slot[0].piece_top  = item.subject_top;
      pieces.slot[0].piece_wide = item.subject_wide;
      pieces.slot[0].piece_tall = item.subject_tall;
      pieces.slot[0].piece_kind = KIND_WHOLE;
      pieces.mask               = 4'b0001;
    end else if (covered) begin
      pieces.slot[0].piece_kind = KIND_NONE;
      pieces.mask               = 4'b0001;
    end else begin
      pieces.slot[0].piece_left = item.subject_left;
      pieces.slot[0].piece_top  = item.subject_top;
      pieces.slot[0].piece_wide = SIZE_BITS'(cl - sl);
      pieces.slot[0].piece_tall = item.subject_tall;
      pieces.slot[0].piece_kind = KIND_LEFT;

      pieces.slot[1].piece_left = cr[COORD_BITS-1:0];
      pieces.slot[1].piece_top  = item.subject_top;
      pieces.slot[1].piece_wide = SIZE_BITS'(sr - cr);
      pieces.slot[1].piece_tall = item.subject_tall;
      pieces.slot[1].piece_kind = KIND_RIGHT;

      pieces.slot[2].piece_left = xl[COORD_BITS-1:0];
      pieces.slot[2].piece_top  = item.subject_top;
      pieces.slot[2].piece_wide = SIZE_BITS'(xr - xl);
      pieces.slot[2].piece_tall = SIZE_BITS'(ct - st);
      pieces.slot[2].piece_kind = KIND_TOP;

      pieces.slot[3].piece_left = xl[COORD_BITS-1:0];
      pieces.slot[3].piece_top  = cb[COORD_BITS-1:0];
      pieces.slot[3].piece_wide = SIZE_BITS'(xr - xl);
      pieces.slot[3].piece_tall = SIZE_BITS'(sb - cb);
      pieces.slot[3].piece_kind = KIND_BOTTOM;

      pieces.mask = {has_bottom, has_top, has_right, has_left};
    end
  end

endmodule

### rtl/core/rsp_emit.sv
`include "assert_macros.svh"

module rsp_emit
  import rsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  piece_set_t pieces,
  output logic       free,
  output logic       strobe,
  output result_t    result
);

  result_t [NUM_SLOTS-1:0] slot;
  logic    [NUM_SLOTS-1:0] mask;
  logic    [NUM_SLOTS-1:0] mask_next;
  logic    [NUM_SLOTS-1:0] rest;
  logic    [1:0]           head;
  result_t                 result_next;

  // Lowest pending slot goes out first; clearing it leaves the rest.
  always_comb begin
    head = 2'd0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) head = 2'(i);
    end
    rest = mask & (mask - 4'd1);
    free = (rest == '0);

    result_next            = slot[head];
    result_next.last_piece = free;
    mask_next              = load ? pieces.mask : rest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask   <= '0;
      strobe <= 1'b0;
    end else begin
      mask   <= mask_next;
      strobe <= |mask;
    end
  end

  always_ff @(posedge clk) begin
    if (load) slot <= pieces.slot;
    result <= result_next;
  end

  `RSP_ASSERT_IMP(a_load_when_free, clk, rst, load, free)
  `RSP_ASSERT_NXT(a_load_fills, clk, rst, load, mask != '0)
  `RSP_ASSERT_NXT(a_item_contiguous, clk, rst, strobe && !result.last_piece, strobe)

endmodule

### rtl/core/rectangle_subtract_pieces.sv
// A taken item goes from the input register to the piece buffer, and each of its pieces is
// registered at the output as a result beat, one beat per cycle. An item yields one to four
// pieces, so an item with more pieces keeps the next one in the input register for longer.
// busy rises only while the input register holds an item that the piece buffer cannot take.
// Reset (rst, synchronous, active high) empties the input register and the piece buffer.
// The receiver cannot stall: every strobe beat is taken in the cycle that it is shown.
module rectangle_subtract_pieces
  import rsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    strobe,
  output result_t result
);

  item_t      held;
  logic       held_valid;
  logic       held_valid_next;
  logic       free;
  logic       load;
  logic       take;
  piece_set_t pieces;

  // The buffer takes a new set once it has at most one piece left, which leaves this cycle.
  assign load = held_valid && free;
  assign busy = held_valid && !free;
  assign take = start && !busy;

  // Hold the item until the buffer takes its pieces; refill in the same cycle.
  always_comb begin
    held_valid_next = take || (held_valid && !free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) held <= item;
  end

  // Work out every strip from the held item in one pass.
  rsp_cut u_cut (
    .item   (held),
    .pieces (pieces)
  );

  // Drain pending pieces in order, one beat per cycle.
  rsp_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .pieces (pieces),
    .free   (free),
    .strobe (strobe),
    .result (result)
  );

endmodule

### bench/rectangle_subtract_pieces_test.sv
`timescale 1ns / 1ps

module rectangle_subtract_pieces_test;
  import rsp_pkg::*;

  localparam int RANDOM_PAIRS = 320;
  localparam int SECOND_DRAIN = 200;  // count of taken beats at which to drain a second time
  localparam int TAIL_CYCLES  = 8;    // room for the pipeline registers plus a full piece buffer
  localparam int DRAIN_LIMIT  = 2000;

  logic    clk;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    strobe;
  result_t result;

  rectangle_subtract_pieces dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  // Rectangle pairs still to be offered, and pieces predicted but not yet seen.
  item_t   rects_waiting[$];
  result_t pieces_due[$];
  int      mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Helpers for building stimulus and predicting pieces
  // ---------------------------------------------------------------------------

  // Pack a subject and a cutter; coordinates wrap to the port widths.
  function automatic item_t rect_pair(int sl, int st, int sw, int sh,
                                      int cl, int ct, int cw, int ch);
    item_t it;
    it.subject_left = sl[COORD_BITS-1:0];
    it.subject_top  = st[COORD_BITS-1:0];
    it.subject_wide = sw[SIZE_BITS-1:0];
    it.subject_tall = sh[SIZE_BITS-1:0];
    it.cutter_left  = cl[COORD_BITS-1:0];
    it.cutter_top   = ct[COORD_BITS-1:0];
    it.cutter_wide  = cw[SIZE_BITS-1:0];
    it.cutter_tall  = ch[SIZE_BITS-1:0];
    return it;
  endfunction

  // Append a pair to the tail of the pending list.
  function automatic void add_rect(item_t it);
    rects_waiting.insert(rects_waiting.size(), it);
  endfunction

  function automatic result_t make_piece(int x, int y, int w, int h, kind_t k);
    result_t r;
    r.piece_left = x[COORD_BITS-1:0];
    r.piece_top  = y[COORD_BITS-1:0];
    r.piece_wide = w[SIZE_BITS-1:0];
    r.piece_tall = h[SIZE_BITS-1:0];
    r.piece_kind = k;
    r.last_piece = 1'b0;
    return r;
  endfunction

  // Work out the strips that remain of the subject once the cutter is taken
  // away, and queue them in emission order with the last one flagged.
  // Edges are held in 32 bits, so right and bottom edges never overflow here;
  // only the piece fields wrap.
  function automatic void cut_subject(item_t it);
    int      sl, st, sw, sh, cl, ct, cw, ch;
    int      sr, sb, cr, cb, xl, xr;
    bit      overlap;
    result_t cut[$];
    result_t r;
    sl = int'($signed(it.subject_left));
    st = int'($signed(it.subject_top));
    sw = int'(it.subject_wide);
    sh = int'(it.subject_tall);
    cl = int'($signed(it.cutter_left));
    ct = int'($signed(it.cutter_top));
    cw = int'(it.cutter_wide);
    ch = int'(it.cutter_tall);
    sr = sl + sw;
    sb = st + sh;
    cr = cl + cw;
    cb = ct + ch;
    // Strict test: rectangles that only touch along an edge do not overlap.
    overlap = (sl < cr) && (sr > cl) && (st < cb) && (sb > ct);
    if (!overlap) begin
      cut.insert(cut.size(), make_piece(sl, st, sw, sh, KIND_WHOLE));
    end else if (cl <= sl && cr >= sr && ct <= st && cb >= sb) begin
      cut.insert(cut.size(), make_piece(0, 0, 0, 0, KIND_NONE));
    end else begin
      xl = (cl > sl) ? cl : sl;
      xr = (cr < sr) ? cr : sr;
      if (cl > sl) cut.insert(cut.size(), make_piece(sl, st, cl - sl, sh, KIND_LEFT));
      if (cr < sr) cut.insert(cut.size(), make_piece(cr, st, sr - cr, sh, KIND_RIGHT));
      if (ct > st) cut.insert(cut.size(), make_piece(xl, st, xr - xl, ct - st, KIND_TOP));
      if (cb < sb) cut.insert(cut.size(), make_piece(xl, cb, xr - xl, sb - cb, KIND_BOTTOM));
    end
    foreach (cut[i]) begin
      r = cut[i];
      r.last_piece = (i == cut.size() - 1);
      pieces_due.insert(pieces_due.size(), r);
    end
  endfunction

  // Extents: mostly small, some anywhere in range, some pinned near the top.
  function automatic int pick_extent();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 8);
      1:       return $urandom_range(1, 200);
      2:       return $urandom_range(0, 32767);
      default: return 32767 - $urandom_range(0, 3);
    endcase
  endfunction

  // Most pairs overlap by construction, so the strip logic gets exercised;
  // the rest are full covers, touching edges or unrelated rectangles.
  function automatic item_t random_pair();
    int sl, st, sw, sh, cl, ct, cw, ch, mode, t;
    sl   = $urandom_range(0, 65535) - 32768;
    st   = $urandom_range(0, 65535) - 32768;
    sw   = pick_extent();
    sh   = pick_extent();
    cw   = pick_extent();
    ch   = pick_extent();
    mode = $urandom_range(0, 9);
    if (mode <= 6) begin
      cl = sl - cw + $urandom_range(0, sw + cw);
      ct = st - ch + $urandom_range(0, sh + ch);
    end else if (mode == 7) begin
      cl = sl - $urandom_range(0, 3);
      ct = st - $urandom_range(0, 3);
      t  = sw + (sl - cl) + $urandom_range(0, 3);
      cw = (t > 32767) ? 32767 : t;
      t  = sh + (st - ct) + $urandom_range(0, 3);
      ch = (t > 32767) ? 32767 : t;
    end else if (mode == 8) begin
      cl = $urandom_range(0, 65535) - 32768;
      ct = $urandom_range(0, 65535) - 32768;
    end else begin
      cl = $urandom_range(0, 1) ? sl + sw : sl - cw;
      ct = st - ch + $urandom_range(0, sh + ch);
    end
    return rect_pair(sl, st, sw, sh, cl, ct, cw, ch);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer one pair per beat, in bursts with random gaps
  // ---------------------------------------------------------------------------
  bit taken;
  bit next_start;
  bit draining = 1'b0;
  int burst_left = 8;
  int gap_left = 0;
  int items_taken = 0;
  int directed_n = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken      = start && !busy;
      next_start = start && !taken;
      // Hold the sender off after the directed part and once more mid-run
      // until every piece predicted so far has come out.
      if (taken) begin
        items_taken++;
        if (items_taken == directed_n || items_taken == SECOND_DRAIN) draining = 1'b1;
      end else if (draining && pieces_due.size() == 0) begin
        draining = 1'b0;
      end
      if (!next_start && !draining) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (rects_waiting.size() > 0) begin
          item <= rects_waiting.pop_front();
          next_start = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // Close the burst; a quarter of the bursts run straight into the next.
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      // One assignment per edge, so a held start never glitches.
      start <= next_start;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every taken beat, check every strobed piece
  // ---------------------------------------------------------------------------
  result_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) cut_subject(item);
      if (strobe) begin
        if (pieces_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected piece left=%0d top=%0d wide=%0d tall=%0d kind=%0d last=%0d",
                   $time, $signed(result.piece_left), $signed(result.piece_top),
                   result.piece_wide, result.piece_tall, result.piece_kind, result.last_piece);
        end else begin
          want = pieces_due.pop_front();
          if (result !== want) begin
            mismatches++;
            $display("%0t: piece mismatch expected left=%0d top=%0d wide=%0d tall=%0d kind=%0d last=%0d",
                     $time, $signed(want.piece_left), $signed(want.piece_top),
                     want.piece_wide, want.piece_tall, want.piece_kind, want.last_piece);
            $display("%0t:                actual   left=%0d top=%0d wide=%0d tall=%0d kind=%0d last=%0d",
                     $time, $signed(result.piece_left), $signed(result.piece_top),
                     result.piece_wide, result.piece_tall, result.piece_kind, result.last_piece);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int waited;
    // Directed pairs: no overlap, touching edges, empty rectangles, full cover,
    // every strip kind alone and together, and edges at the coordinate limits.
    add_rect(rect_pair(0, 0, 10, 10, 20, 20, 5, 5));
    add_rect(rect_pair(0, 0, 10, 10, 10, 0, 5, 10));
    add_rect(rect_pair(0, 0, 0, 10, 0, 0, 10, 10));
    add_rect(rect_pair(0, 0, 10, 10, 2, 2, 0, 5));
    add_rect(rect_pair(5, 5, 10, 10, 5, 5, 10, 10));
    add_rect(rect_pair(5, 5, 10, 10, 0, 0, 30, 30));
    add_rect(rect_pair(0, 0, 10, 10, 3, 3, 4, 4));
    add_rect(rect_pair(0, 0, 10, 10, -5, 3, 8, 4));
    add_rect(rect_pair(0, 0, 10, 10, 3, -5, 4, 20));
    add_rect(rect_pair(0, 0, 10, 10, 3, -5, 20, 8));
    add_rect(rect_pair(0, 0, 10, 10, -5, 5, 30, 10));
    add_rect(rect_pair(0, 0, 10, 10, -5, -5, 30, 10));
    add_rect(rect_pair(0, 0, 10, 10, 5, -5, 30, 30));
    add_rect(rect_pair(0, 0, 2, 2, 1, 1, 1, 1));
    add_rect(rect_pair(0, 0, 1, 1, 0, 0, 1, 1));
    add_rect(rect_pair(-32768, -32768, 32767, 32767, -32768, -32768, 1, 1));
    // Right strip and bottom strip edges past the signed range: they wrap.
    add_rect(rect_pair(32767, 32767, 32767, 32767, 32767, 32767, 1, 1));
    add_rect(rect_pair(32767, 0, 32767, 10, 32767, 0, 1, 10));
    add_rect(rect_pair(-32768, -32768, 32767, 32767,
                       -32768, -32768, 32767, 32767));
    add_rect(rect_pair(-1, -1, 32767, 32767, -32768, -32768, 32767, 32767));
    add_rect(rect_pair(-32768, 32767, 32767, 0, 32767, -32768, 32767, 32767));
    add_rect(rect_pair(100, 100, 32767, 32767, 200, 200, 100, 100));
    directed_n = rects_waiting.size();
    repeat (RANDOM_PAIRS) add_rect(random_pair());

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait for every pair to be taken, then for the pieces still owed.
    while (rects_waiting.size() != 0 || start) @(posedge clk);
    waited = 0;
    while (pieces_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pieces_due.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected pieces never came out", $time, pieces_due.size());
    end
    // Let any stray beats show before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[rectangle_subtract_pieces] OK");
    else
      $display("[rectangle_subtract_pieces] ERROR");
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("[rectangle_subtract_pieces] ERROR");
    $finish;
  end

endmodule
